### hw/rtl/dpd_pkg.sv
package dpd_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;
    localparam int GAIN_W     = 11;
    localparam int BIAS_W     = 10;
    localparam int LVL_W      = 8;
    localparam int INTEG_W    = 32;
    localparam int DRIVE_W    = 9;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GAIN_P         = 3'd0,
        REG_GAIN_I         = 3'd1,
        REG_GAIN_D         = 3'd2,
        REG_DRIVE_BIAS     = 3'd3,
        REG_DRIVE_LIMIT    = 3'd4,
        REG_KICK_LEVEL     = 3'd5,
        REG_KICK_POS_FLOOR = 3'd6,
        REG_KICK_NEG_FLOOR = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic signed [GAIN_W-1:0] gain_p;
        logic signed [GAIN_W-1:0] gain_i;
        logic signed [GAIN_W-1:0] gain_d;
        logic        [BIAS_W-1:0] drive_bias;
        logic        [LVL_W-1:0]  drive_limit;
        logic        [LVL_W-1:0]  kick_level;
        logic        [LVL_W-1:0]  kick_pos_floor;
        logic        [LVL_W-1:0]  kick_neg_floor;
    } t_cfg;

    localparam logic signed [GAIN_W-1:0] RST_GAIN_P         = 11'sd50;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_I         = 11'sd3;
    localparam logic signed [GAIN_W-1:0] RST_GAIN_D         = -11'sd20;
    localparam logic        [BIAS_W-1:0] RST_DRIVE_BIAS     = 10'd200;
    localparam logic        [LVL_W-1:0]  RST_DRIVE_LIMIT    = 8'd255;
    localparam logic        [LVL_W-1:0]  RST_KICK_LEVEL     = 8'd60;
    localparam logic        [LVL_W-1:0]  RST_KICK_POS_FLOOR = 8'd5;
    localparam logic        [LVL_W-1:0]  RST_KICK_NEG_FLOOR = 8'd25;

endpackage

### hw/rtl/dpd_cfg.sv
module dpd_cfg import dpd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  logic [CFG_IDX_W-1:0]  i_index,
    input  logic [CFG_DATA_W-1:0] i_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p         <= RST_GAIN_P;
            r_cfg.gain_i         <= RST_GAIN_I;
            r_cfg.gain_d         <= RST_GAIN_D;
            r_cfg.drive_bias     <= RST_DRIVE_BIAS;
            r_cfg.drive_limit    <= RST_DRIVE_LIMIT;
            r_cfg.kick_level     <= RST_KICK_LEVEL;
            r_cfg.kick_pos_floor <= RST_KICK_POS_FLOOR;
            r_cfg.kick_neg_floor <= RST_KICK_NEG_FLOOR;
        end else if (i_we) begin
            unique case (t_cfg_reg'(i_index))
                REG_GAIN_P:         r_cfg.gain_p         <= $signed(i_data[GAIN_W-1:0]);
                REG_GAIN_I:         r_cfg.gain_i         <= $signed(i_data[GAIN_W-1:0]);
                REG_GAIN_D:         r_cfg.gain_d         <= $signed(i_data[GAIN_W-1:0]);
                REG_DRIVE_BIAS:     r_cfg.drive_bias     <= i_data[BIAS_W-1:0];
                REG_DRIVE_LIMIT:    r_cfg.drive_limit    <= i_data[LVL_W-1:0];
                REG_KICK_LEVEL:     r_cfg.kick_level     <= i_data[LVL_W-1:0];
                REG_KICK_POS_FLOOR: r_cfg.kick_pos_floor <= i_data[LVL_W-1:0];
                REG_KICK_NEG_FLOOR: r_cfg.kick_neg_floor <= i_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/dpd_law.sv
module dpd_law import dpd_pkg::*; #(
    parameter int SAMPLE_BITS = 12
) (
    input  t_cfg                            i_cfg,
    input  logic        [SAMPLE_BITS-1:0]   i_left,
    input  logic        [SAMPLE_BITS-1:0]   i_right,
    input  logic signed [SAMPLE_BITS:0]     i_prev_err,
    input  logic signed [INTEG_W-1:0]       i_integ_l,
    input  logic signed [INTEG_W-1:0]       i_integ_r,
    output logic signed [SAMPLE_BITS:0]     o_err,
    output logic signed [INTEG_W-1:0]       o_integ_l,
    output logic signed [INTEG_W-1:0]       o_integ_r,
    output logic signed [DRIVE_W-1:0]       o_drive_l,
    output logic signed [DRIVE_W-1:0]       o_drive_r
);

    localparam int ERR_W  = SAMPLE_BITS + 1;
    localparam int DERR_W = ERR_W + 1;
    localparam int P_W    = GAIN_W + ERR_W;
    localparam int D_W    = GAIN_W + DERR_W;
    localparam int I_W    = GAIN_W + INTEG_W;
    localparam int SUM_W  = ((I_W > D_W) ? I_W : D_W) + 3;

    function automatic logic [DRIVE_W:0] clamp_drive(
        input logic signed [SUM_W-1:0] v,
        input logic        [LVL_W-1:0] lim
    );
        logic signed [SUM_W-1:0]   lim_s;
        logic signed [DRIVE_W-1:0] lim_d;
        lim_s = SUM_W'($signed({1'b0, lim}));
        lim_d = $signed({1'b0, lim});
        if (v > lim_s)
            return {1'b1, lim_d};
        else if (v < -lim_s)
            return {1'b1, -lim_d};
        else
            return {1'b0, v[DRIVE_W-1:0]};
    endfunction

    function automatic logic signed [DRIVE_W-1:0] kick(
        input logic signed [DRIVE_W-1:0] d,
        input logic        [LVL_W-1:0]   lvl,
        input logic        [LVL_W-1:0]   pos_floor,
        input logic        [LVL_W-1:0]   neg_floor
    );
        logic signed [DRIVE_W:0]   dx;
        logic signed [DRIVE_W:0]   lvl_s;
        logic signed [DRIVE_W:0]   pos_s;
        logic signed [DRIVE_W:0]   neg_s;
        logic signed [DRIVE_W-1:0] lvl_d;
        dx    = {d[DRIVE_W-1], d};
        lvl_s = $signed({2'b00, lvl});
        pos_s = $signed({2'b00, pos_floor});
        neg_s = $signed({2'b00, neg_floor});
        lvl_d = $signed({1'b0, lvl});
        if (dx < lvl_s && dx > pos_s)
            return lvl_d;
        else if (dx > -lvl_s && dx < -neg_s)
            return -lvl_d;
        else
            return d;
    endfunction

    function automatic logic signed [INTEG_W-1:0] sat_add(
        input logic signed [INTEG_W-1:0] acc,
        input logic signed [ERR_W-1:0]   e
    );
        logic signed [INTEG_W:0] s;
        s = (INTEG_W+1)'(acc) + (INTEG_W+1)'(e);
        if (s[INTEG_W] != s[INTEG_W-1])
            return s[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
        else
            return s[INTEG_W-1:0];
    endfunction

    logic signed [ERR_W-1:0]  w_err;
    logic signed [DERR_W-1:0] w_derr;
    logic signed [P_W-1:0]    w_p;
    logic signed [D_W-1:0]    w_d;
    logic signed [I_W-1:0]    w_il;
    logic signed [I_W-1:0]    w_ir;
    logic signed [SUM_W-1:0]  w_pd;
    logic signed [SUM_W-1:0]  w_bias;
    logic signed [SUM_W-1:0]  w_raw_l;
    logic signed [SUM_W-1:0]  w_raw_r;
    logic        [DRIVE_W:0]  w_cl_l;
    logic        [DRIVE_W:0]  w_cl_r;

    assign w_err  = $signed({1'b0, i_left}) - $signed({1'b0, i_right});
    assign w_derr = DERR_W'(w_err) - DERR_W'(i_prev_err);

    assign w_p  = i_cfg.gain_p * w_err;
    assign w_d  = i_cfg.gain_d * w_derr;
    assign w_il = i_cfg.gain_i * i_integ_l;
    assign w_ir = i_cfg.gain_i * i_integ_r;

    assign w_pd    = SUM_W'(w_p) + SUM_W'(w_d);
    assign w_bias  = SUM_W'($signed({1'b0, i_cfg.drive_bias}));
    assign w_raw_l = -(w_pd + SUM_W'(w_il) + w_bias);
    assign w_raw_r = w_pd + SUM_W'(w_ir) - w_bias;

    assign w_cl_l = clamp_drive(w_raw_l, i_cfg.drive_limit);
    assign w_cl_r = clamp_drive(w_raw_r, i_cfg.drive_limit);

    assign o_err     = w_err;
    assign o_integ_l = w_cl_l[DRIVE_W] ? i_integ_l : sat_add(i_integ_l, w_err);
    assign o_integ_r = w_cl_r[DRIVE_W] ? i_integ_r : sat_add(i_integ_r, w_err);
    assign o_drive_l = kick($signed(w_cl_l[DRIVE_W-1:0]), i_cfg.kick_level,
                            i_cfg.kick_pos_floor, i_cfg.kick_neg_floor);
    assign o_drive_r = kick($signed(w_cl_r[DRIVE_W-1:0]), i_cfg.kick_level,
                            i_cfg.kick_pos_floor, i_cfg.kick_neg_floor);

endmodule

### hw/rtl/differential_pid_drive.sv
// Differential PID drive: takes one left/right distance pair per transaction and returns one
// pair of signed motor drives per transaction. A new pair is accepted every clock cycle unless
// o_in_stall is raised; a result passes through the input register, then the result register.
// The integrators and the previous error are updated in the same cycle that a result is formed,
// so the path through the 11x32 integral-gain multiply, the sum, the clamp and the saturating
// integrator add sets the clock. A stalled result holds in the result register while one
// further input waits in the input register. Configuration is written through a plain write
// port and must only change while the block is idle.
module differential_pid_drive import dpd_pkg::*; #(
    parameter int SAMPLE_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [SAMPLE_BITS-1:0]    i_dist_left,
    input  logic [SAMPLE_BITS-1:0]    i_dist_right,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic signed [DRIVE_W-1:0] o_drive_left,
    output logic signed [DRIVE_W-1:0] o_drive_right
);

    localparam int ERR_W = SAMPLE_BITS + 1;

    t_cfg w_cfg;

    logic                      r_in_valid;
    logic [SAMPLE_BITS-1:0]    r_left;
    logic [SAMPLE_BITS-1:0]    r_right;
    logic signed [ERR_W-1:0]   r_prev_err;
    logic signed [INTEG_W-1:0] r_integ_l;
    logic signed [INTEG_W-1:0] r_integ_r;
    logic                      r_out_valid;
    logic signed [DRIVE_W-1:0] r_drive_l;
    logic signed [DRIVE_W-1:0] r_drive_r;

    logic signed [ERR_W-1:0]   n_prev_err;
    logic signed [INTEG_W-1:0] n_integ_l;
    logic signed [INTEG_W-1:0] n_integ_r;
    logic signed [DRIVE_W-1:0] n_drive_l;
    logic signed [DRIVE_W-1:0] n_drive_r;

    logic w_fire;

    dpd_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_we    (i_cfg_we),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    dpd_law #(.SAMPLE_BITS(SAMPLE_BITS)) u_law (
        .i_cfg      (w_cfg),
        .i_left     (r_left),
        .i_right    (r_right),
        .i_prev_err (r_prev_err),
        .i_integ_l  (r_integ_l),
        .i_integ_r  (r_integ_r),
        .o_err      (n_prev_err),
        .o_integ_l  (n_integ_l),
        .o_integ_r  (n_integ_r),
        .o_drive_l  (n_drive_l),
        .o_drive_r  (n_drive_r)
    );

    assign w_fire     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_left  <= i_dist_left;
            r_right <= i_dist_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_err <= '0;
            r_integ_l  <= '0;
            r_integ_r  <= '0;
        end else if (w_fire) begin
            r_prev_err <= n_prev_err;
            r_integ_l  <= n_integ_l;
            r_integ_r  <= n_integ_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_drive_l <= n_drive_l;
            r_drive_r <= n_drive_r;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_drive_left  = r_drive_l;
    assign o_drive_right = r_drive_r;

`ifndef SYNTHESIS
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("computed transaction did not reach the result register");

    a_state_holds_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fire |=> $stable(r_integ_l) && $stable(r_integ_r) && $stable(r_prev_err))
        else $error("controller state changed without a transaction");

    a_drive_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_drive_left != {1'b1, {(DRIVE_W-1){1'b0}}})
                     && (o_drive_right != {1'b1, {(DRIVE_W-1){1'b0}}}))
        else $error("drive out of range");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |-> !w_fire)
        else $error("stalled result overwritten");
`endif

endmodule

### sim/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import dpd_pkg::*;

    localparam int SB = 12;
    localparam int SMAX = (1 << SB) - 1;
    localparam longint CYCLE_LIMIT = 200000;
    localparam int RAMP_ITEMS = 60;
    localparam longint INT32_HI = 64'sh7FFF_FFFF;
    localparam longint INT32_LO = -64'sh8000_0000;

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
    } t_drive_pair;

    class t_drive_tracker;
        longint gain_p, gain_i, gain_d, bias, limit, level, pos_floor, neg_floor;
        longint last_err, integ_left, integ_right;
        t_drive_pair expected_drives[$];
        int mismatches;
        int results_seen;

        function new();
            gain_p = 50;
            gain_i = 3;
            gain_d = -20;
            bias = 200;
            limit = 255;
            level = 60;
            pos_floor = 5;
            neg_floor = 25;
            last_err = 0;
            integ_left = 0;
            integ_right = 0;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void load_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] v);
            case (idx)
                REG_GAIN_P:         gain_p = longint'($signed(v[GAIN_W-1:0]));
                REG_GAIN_I:         gain_i = longint'($signed(v[GAIN_W-1:0]));
                REG_GAIN_D:         gain_d = longint'($signed(v[GAIN_W-1:0]));
                REG_DRIVE_BIAS:     bias = longint'(v[BIAS_W-1:0]);
                REG_DRIVE_LIMIT:    limit = longint'(v[LVL_W-1:0]);
                REG_KICK_LEVEL:     level = longint'(v[LVL_W-1:0]);
                REG_KICK_POS_FLOOR: pos_floor = longint'(v[LVL_W-1:0]);
                REG_KICK_NEG_FLOOR: neg_floor = longint'(v[LVL_W-1:0]);
                default: ;
            endcase
        endfunction

        function longint sat_add(longint acc, longint e);
            longint s;
            s = acc + e;
            if (s > INT32_HI) return INT32_HI;
            if (s < INT32_LO) return INT32_LO;
            return s;
        endfunction

        function longint apply_kick(longint d);
            if (d < level && d > pos_floor) return level;
            if (d > -level && d < -neg_floor) return -level;
            return d;
        endfunction

        function void accept_sample(logic [SB-1:0] l, logic [SB-1:0] r);
            longint err, derr, dl, dr;
            t_drive_pair p;
            err = longint'(l) - longint'(r);
            derr = err - last_err;
            dl = -(gain_p * err + gain_i * integ_left + gain_d * derr + bias);
            dr = -(-gain_p * err - gain_i * integ_right - gain_d * derr + bias);
            // integrate only when that side stays inside the limit
            if (dl > limit) dl = limit;
            else if (dl < -limit) dl = -limit;
            else integ_left = sat_add(integ_left, err);
            if (dr > limit) dr = limit;
            else if (dr < -limit) dr = -limit;
            else integ_right = sat_add(integ_right, err);
            dl = apply_kick(dl);
            dr = apply_kick(dr);
            last_err = err;
            p.left = dl[DRIVE_W-1:0];
            p.right = dr[DRIVE_W-1:0];
            expected_drives.push_back(p);
        endfunction

        function void check_drive(logic signed [DRIVE_W-1:0] l, logic signed [DRIVE_W-1:0] r);
            t_drive_pair p;
            if (expected_drives.size() == 0) begin
                $error("drive result with no pending transaction: left %0d right %0d", l, r);
                mismatches++;
                return;
            end
            p = expected_drives.pop_front();
            results_seen++;
            if (l !== p.left) begin
                $error("drive_left: expected %0d, got %0d", p.left, l);
                mismatches++;
            end
            if (r !== p.right) begin
                $error("drive_right: expected %0d, got %0d", p.right, r);
                mismatches++;
            end
        endfunction
    endclass

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_index;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_in_valid;
    logic                      o_in_stall;
    logic [SB-1:0]             i_dist_left;
    logic [SB-1:0]             i_dist_right;
    logic                      o_out_valid;
    logic                      i_out_stall;
    logic signed [DRIVE_W-1:0] o_drive_left;
    logic signed [DRIVE_W-1:0] o_drive_right;

    differential_pid_drive #(.SAMPLE_BITS(SB)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_dist_left   (i_dist_left),
        .i_dist_right  (i_dist_right),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_drive_left  (o_drive_left),
        .o_drive_right (o_drive_right)
    );

    t_drive_tracker tracker = new();
    bit no_idle = 1'b0;
    int rx_hold_req = 0;
    int pairs_sent = 0;
    int settings_used = 1;
    longint cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("[differential_pid_drive] ERROR");
                $finish;
            end
        end
    end

    function automatic int gap_draw();
        if (no_idle) return 0;
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 19);
    endfunction

    // result side: one stall draw per transaction, plus one long hold
    initial begin : drive_sink
        int n;
        i_out_stall <= 1'b1;
        wait (i_rst_n === 1'b1);
        forever begin
            if (rx_hold_req > 0) begin
                n = rx_hold_req;
                rx_hold_req = 0;
            end else begin
                n = gap_draw();
            end
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            tracker.check_drive(o_drive_left, o_drive_right);
        end
    end

    // valid stays high across back-to-back transactions
    task automatic send_pair(input int l, input int r, input int gap);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_dist_left <= SB'(l);
        i_dist_right <= SB'(r);
        do @(posedge i_clk); while (o_in_stall);
        tracker.accept_sample(SB'(l), SB'(r));
        pairs_sent++;
    endtask

    task automatic send_random();
        int m, base, other, l, r;
        m = $urandom_range(0, 9);
        if (m < 6) begin
            base = $urandom_range(0, SMAX);
            other = base + $urandom_range(0, 40) - 20;
            if (other < 0) other = 0;
            if (other > SMAX) other = SMAX;
            l = base;
            r = other;
        end else if (m < 8) begin
            l = $urandom;
            r = $urandom;
        end else if (m == 8) begin
            l = $urandom_range(0, 1) ? SMAX : 0;
            r = $urandom_range(0, 1) ? SMAX : 0;
        end else begin
            l = $urandom;
            r = l;
        end
        send_pair(l, r, gap_draw());
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (tracker.expected_drives.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= CFG_DATA_W'(v);
        @(posedge i_clk);
        tracker.load_reg(idx, CFG_DATA_W'(v));
    endtask

    task automatic apply_config(input int gp, input int gi, input int gd, input int bias,
                                input int lim, input int lvl, input int pf, input int nf);
        write_reg(REG_GAIN_P, gp);
        write_reg(REG_GAIN_I, gi);
        write_reg(REG_GAIN_D, gd);
        write_reg(REG_DRIVE_BIAS, bias);
        write_reg(REG_DRIVE_LIMIT, lim);
        write_reg(REG_KICK_LEVEL, lvl);
        write_reg(REG_KICK_POS_FLOOR, pf);
        write_reg(REG_KICK_NEG_FLOOR, nf);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic int pick(int lo, int hi);
        return $urandom_range(0, hi - lo) + lo;
    endfunction

    task automatic random_config(input int kind);
        int lvl;
        case (kind)
            1: apply_config(1023, 1023, 1023, 1023, 255, 255, 255, 255);
            3: apply_config(-1024, -1024, -1024, 0, 0, 0, 0, 0);
            4: begin
                lvl = pick(100, 255);
                apply_config(pick(-8, 8), pick(-4, 4), pick(-8, 8), pick(0, 30),
                             pick(0, 40), lvl, pick(0, 20), pick(0, 20));
            end
            2, 5: apply_config($urandom, $urandom, $urandom, $urandom,
                               $urandom, $urandom, $urandom, $urandom);
            7: apply_config(50, 3, -20, 200, 255, 60, 5, 25);
            default: begin
                lvl = pick(0, 255);
                apply_config(pick(-8, 8), pick(-3, 3), pick(-8, 8), pick(0, 60),
                             pick(20, 255), lvl, pick(0, lvl), pick(0, lvl));
            end
        endcase
    endtask

    initial begin : stimulus
        int ph, k;
        i_rst_n <= 1'b0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= REG_GAIN_P;
        i_cfg_data <= '0;
        i_in_valid <= 1'b0;
        i_dist_left <= '0;
        i_dist_right <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings, sample extremes
        send_pair(0, 0, gap_draw());
        send_pair(SMAX, 0, gap_draw());
        send_pair(0, SMAX, gap_draw());
        send_pair(SMAX, SMAX, gap_draw());
        send_pair(2048, 2047, gap_draw());
        send_pair(2047, 2048, gap_draw());
        drain();

        // pure P: kick thresholds on both sides, boundaries included
        apply_config(1, 0, 0, 0, 255, 60, 5, 25);
        send_pair(0, 10, gap_draw());
        send_pair(30, 0, gap_draw());
        send_pair(5, 0, gap_draw());
        send_pair(6, 0, gap_draw());
        send_pair(0, 26, gap_draw());
        send_pair(60, 0, gap_draw());
        send_pair(0, 60, gap_draw());
        drain();

        // kick level above the limit, with clamped integration
        apply_config(1, 2, 0, 0, 20, 100, 5, 25);
        send_pair(0, 10, gap_draw());
        send_pair(0, 50, gap_draw());
        send_pair(0, 50, gap_draw());
        send_pair(50, 0, gap_draw());
        send_pair(0, 0, gap_draw());
        drain();

        for (ph = 0; ph < 8; ph++) begin
            random_config(ph);
            no_idle = (ph == 2 || ph == 5);
            if (ph == 2) rx_hold_req = 150;
            for (k = 0; k < 84; k++) send_random();
            drain();
        end

        // full-rate run with a constant error to ramp both integrators
        apply_config(0, 0, 0, 0, 255, 0, 0, 0);
        no_idle = 1'b1;
        for (k = 0; k < RAMP_ITEMS; k++) send_pair(SMAX, 0, 0);
        drain();
        apply_config(0, 1, 0, 0, 100, 0, 0, 0);
        send_pair(0, 0, 0);
        send_pair(0, 0, 0);
        send_pair(0, SMAX, 0);
        send_pair(0, SMAX, 0);
        send_pair(SMAX, 0, 0);
        drain();
        repeat (10) @(posedge i_clk);

        $display("%0d sample pairs over %0d register settings, %0d drive results checked",
                 pairs_sent, settings_used, tracker.results_seen);
        $display("kick edges, kick above limit, anti-windup, back-pressure hold");
        if (tracker.mismatches == 0 && tracker.expected_drives.size() == 0) begin
            $display("[differential_pid_drive] OK");
        end else begin
            $display("[differential_pid_drive] ERROR");
        end
        $finish;
    end
endmodule

### files.f
hw/rtl/dpd_pkg.sv
hw/rtl/dpd_cfg.sv
hw/rtl/dpd_law.sv
hw/rtl/differential_pid_drive.sv
sim/testbench.sv
